// ===== rtl/vertex_transform_4x4_assert.svh =====
`ifndef VERTEX_TRANSFORM_4X4_ASSERT_SVH
`define VERTEX_TRANSFORM_4X4_ASSERT_SVH

// Check that a condition holds in the same cycle as its trigger.
`define VT44_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vertex transform check failed");

// Check that a condition holds in the cycle after its trigger.
`define VT44_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vertex transform check failed");

`endif

// ===== rtl/vt44_pkg.sv =====
package vt44_pkg;

    // Default number of fraction bits of the fixed point format.
    localparam int FRAC_BITS_DEF = 16;

    // Widths of the datapath, sized for the smallest supported fraction width.
    localparam int SUM_W = 68;  // exact sum of three products and the translation
    localparam int LIN_W = 61;  // rounded linear combination, signed
    localparam int MAG_W = 60;  // magnitude of a linear combination
    localparam int NUM_W = 68;  // dividend, magnitude shifted up by the fraction
    localparam int Q_W   = 33;  // quotient bits produced by the divider chain
    localparam int REM_W = 61;  // partial remainder

    localparam int NUM_REGS = 8;
    localparam int IDX_W    = 4;

    // Operation codes.
    typedef enum logic [1:0] {
        OP_AFFINE  = 2'd0,
        OP_PROJECT = 2'd1,
        OP_NORMAL  = 2'd2,
        OP_UNUSED  = 2'd3
    } t_op;

    // One divider lane: partial remainder, remaining dividend bits, quotient.
    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [Q_W-1:0]   nlow;
        logic [Q_W-1:0]   quo;
        logic             neg;
        logic             ovf;
    } t_lane;

    // Everything one item carries down the divider chain.
    typedef struct packed {
        logic              vld;
        logic              div;
        logic              zw;
        logic [MAG_W-1:0]  den;
        t_lane [2:0]       lane;
        logic [2:0][31:0]  res;
        logic              flt;
    } t_div;

endpackage

// ===== rtl/vt44_mac.sv =====
module vt44_mac #(
    parameter int FRAC_BITS = vt44_pkg::FRAC_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic signed [31:0]                i_x,
    input  logic signed [31:0]                i_y,
    input  logic signed [31:0]                i_z,
    input  logic signed [31:0]                i_m0,
    input  logic signed [31:0]                i_m1,
    input  logic signed [31:0]                i_m2,
    input  logic signed [31:0]                i_m3,
    input  logic                              i_trans,
    output logic signed [vt44_pkg::LIN_W-1:0] o_lin
);

    logic signed [63:0] r_p0, r_p1, r_p2;
    logic signed [31:0] r_m3;
    logic               r_trans;
    logic signed [vt44_pkg::SUM_W-1:0] n_sum, r_sum, w_shift, w_tr;

    // First stage: the three products.
    always_ff @(posedge i_clk) begin
        r_p0    <= i_x * i_m0;
        r_p1    <= i_y * i_m1;
        r_p2    <= i_z * i_m2;
        r_m3    <= i_m3;
        r_trans <= i_trans;
    end

    // Second stage: exact sum with translation and the rounding half.
    always_comb begin
        w_tr  = r_trans ? (vt44_pkg::SUM_W'(r_m3) <<< FRAC_BITS) : '0;
        n_sum = vt44_pkg::SUM_W'(r_p0) + vt44_pkg::SUM_W'(r_p1) + vt44_pkg::SUM_W'(r_p2)
              + w_tr + (vt44_pkg::SUM_W'(1) << (FRAC_BITS - 1));
    end

    always_ff @(posedge i_clk) begin
        r_sum <= n_sum;
    end

    // Floor to the fraction width.
    assign w_shift = r_sum >>> FRAC_BITS;
    assign o_lin   = w_shift[vt44_pkg::LIN_W-1:0];

endmodule

// ===== rtl/vt44_div_cell.sv =====
module vt44_div_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  vt44_pkg::t_div i_d,
    output vt44_pkg::t_div o_d
);

    vt44_pkg::t_div n_d, r_d;
    logic [vt44_pkg::REM_W:0] w_try [3];

    // One restoring division step in each of the three lanes.
    always_comb begin
        n_d = i_d;
        for (int j = 0; j < 3; j++) begin
            w_try[j] = {i_d.lane[j].rem, i_d.lane[j].nlow[vt44_pkg::Q_W-1]};
            n_d.lane[j].nlow = {i_d.lane[j].nlow[vt44_pkg::Q_W-2:0], 1'b0};
            if (w_try[j] >= (vt44_pkg::REM_W+1)'(i_d.den)) begin
                n_d.lane[j].rem = vt44_pkg::REM_W'(w_try[j] - (vt44_pkg::REM_W+1)'(i_d.den));
                n_d.lane[j].quo = {i_d.lane[j].quo[vt44_pkg::Q_W-2:0], 1'b1};
            end else begin
                n_d.lane[j].rem = w_try[j][vt44_pkg::REM_W-1:0];
                n_d.lane[j].quo = {i_d.lane[j].quo[vt44_pkg::Q_W-2:0], 1'b0};
            end
        end
    end

    // Hand the item on to the next cell.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d.vld <= 1'b0;
        end else begin
            r_d.vld <= n_d.vld;
        end
        r_d.div  <= n_d.div;
        r_d.zw   <= n_d.zw;
        r_d.den  <= n_d.den;
        r_d.lane <= n_d.lane;
        r_d.res  <= n_d.res;
        r_d.flt  <= n_d.flt;
    end

    assign o_d = r_d;

endmodule

// ===== rtl/vertex_transform_4x4.sv =====
// Start to o_done: the MAC stages, setup register, divider chain and output register.
// Throughput: one vertex per cycle; busy stays low and start may be high every cycle.
// The 33-cell divider chain, one quotient bit per cell, sets the latency in every mode.
// Results are strobed for one cycle; the receiver cannot stall the pipeline.
// Synchronous active-low reset clears the pipeline valid bits and loads the identity matrix.
`include "vertex_transform_4x4_assert.svh"

module vertex_transform_4x4 #(
    parameter int FRAC_BITS = vt44_pkg::FRAC_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [1:0]                     i_operation,
    input  logic signed [31:0]             i_in_x,
    input  logic signed [31:0]             i_in_y,
    input  logic signed [31:0]             i_in_z,
    input  logic                           i_cfg_we,
    input  logic [vt44_pkg::IDX_W-1:0]     i_cfg_idx,
    input  logic [63:0]                    i_cfg_data,
    output logic                           o_done,
    output logic signed [31:0]             o_out_x,
    output logic signed [31:0]             o_out_y,
    output logic signed [31:0]             o_out_z,
    output logic                           o_fault
);

    localparam int NCELL = vt44_pkg::Q_W;
    localparam int LAT   = NCELL + 4;

    logic [63:0] r_mat [vt44_pkg::NUM_REGS];
    logic signed [31:0] w_m [4][4];

    logic r_v1, r_v2;
    logic [1:0] r_op1, r_op2;
    logic w_trans;
    logic signed [vt44_pkg::LIN_W-1:0] w_lin [4];

    vt44_pkg::t_div n_pre, r_pre;
    vt44_pkg::t_div w_chain [NCELL+1];
    vt44_pkg::t_div w_last;

    logic [vt44_pkg::MAG_W-1:0] w_an [3];
    logic [vt44_pkg::NUM_W-1:0] w_num [3];
    logic [vt44_pkg::NUM_W-vt44_pkg::Q_W-1:0] w_top [3];
    logic [vt44_pkg::LIN_W-1:0] w_wneg, w_nneg [3];

    logic [vt44_pkg::Q_W:0] w_q [3];
    logic [2:0] w_rnd, w_sat;
    logic [2:0][31:0] w_val;
    logic r_done, r_fault;
    logic [31:0] r_x, r_y, r_z;

    assign busy = 1'b0;

    // Matrix registers, identity after reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mat[0] <= 64'(1) << FRAC_BITS;
            r_mat[1] <= '0;
            r_mat[2] <= 64'(1) << (FRAC_BITS + 32);
            r_mat[3] <= '0;
            r_mat[4] <= '0;
            r_mat[5] <= 64'(1) << FRAC_BITS;
            r_mat[6] <= '0;
            r_mat[7] <= 64'(1) << (FRAC_BITS + 32);
        end else if (i_cfg_we && (i_cfg_idx < vt44_pkg::IDX_W'(vt44_pkg::NUM_REGS))) begin
            r_mat[i_cfg_idx[2:0]] <= i_cfg_data;
        end
    end

    // Unpack the entries: row r, column c.
    always_comb begin
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                w_m[r][c] = (c % 2 == 1) ? r_mat[r*2 + c/2][63:32] : r_mat[r*2 + c/2][31:0];
            end
        end
    end

    // Control alongside the two multiply-accumulate stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= start && !busy;
            r_v2 <= r_v1;
        end
        r_op1 <= i_operation;
        r_op2 <= r_op1;
    end

    assign w_trans = (i_operation == vt44_pkg::OP_AFFINE) || (i_operation == vt44_pkg::OP_PROJECT);

    // One multiply-accumulate unit per column.
    for (genvar c = 0; c < 4; c++) begin : g_col
        vt44_mac #(.FRAC_BITS(FRAC_BITS)) u_mac (
            .i_clk   (i_clk),
            .i_x     (i_in_x),
            .i_y     (i_in_y),
            .i_z     (i_in_z),
            .i_m0    (w_m[0][c]),
            .i_m1    (w_m[1][c]),
            .i_m2    (w_m[2][c]),
            .i_m3    (w_m[3][c]),
            .i_trans (w_trans),
            .o_lin   (w_lin[c])
        );
    end

    // Divider setup and the results of the modes without a divide.
    always_comb begin
        n_pre     = '0;
        n_pre.vld = r_v2;
        n_pre.div = (r_op2 == vt44_pkg::OP_PROJECT);
        n_pre.zw  = (w_lin[3] == '0);
        w_wneg    = -w_lin[3];
        n_pre.den = w_lin[3][vt44_pkg::LIN_W-1] ? w_wneg[vt44_pkg::MAG_W-1:0]
                                                : w_lin[3][vt44_pkg::MAG_W-1:0];
        for (int j = 0; j < 3; j++) begin
            w_nneg[j] = -w_lin[j];
            w_an[j]   = w_lin[j][vt44_pkg::LIN_W-1] ? w_nneg[j][vt44_pkg::MAG_W-1:0]
                                                    : w_lin[j][vt44_pkg::MAG_W-1:0];
            w_num[j]  = vt44_pkg::NUM_W'(w_an[j]) << FRAC_BITS;
            w_top[j]  = w_num[j][vt44_pkg::NUM_W-1:vt44_pkg::Q_W];
            n_pre.lane[j].rem  = vt44_pkg::REM_W'(w_top[j]);
            n_pre.lane[j].nlow = w_num[j][vt44_pkg::Q_W-1:0];
            n_pre.lane[j].neg  = w_lin[j][vt44_pkg::LIN_W-1] ^ w_lin[3][vt44_pkg::LIN_W-1];
            n_pre.lane[j].ovf  = vt44_pkg::NUM_W'(w_top[j]) >= vt44_pkg::NUM_W'(n_pre.den);
            if (w_lin[j] > vt44_pkg::LIN_W'(32'sh7FFF_FFFF)) begin
                n_pre.res[j] = 32'h7FFF_FFFF;
                n_pre.flt    = 1'b1;
            end else if (w_lin[j] < vt44_pkg::LIN_W'(-33'sh8000_0000)) begin
                n_pre.res[j] = 32'h8000_0000;
                n_pre.flt    = 1'b1;
            end else begin
                n_pre.res[j] = w_lin[j][31:0];
            end
        end
        if (r_op2 == vt44_pkg::OP_UNUSED) begin
            n_pre.res = '0;
            n_pre.flt = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pre.vld <= 1'b0;
        end else begin
            r_pre.vld <= n_pre.vld;
        end
        r_pre.div  <= n_pre.div;
        r_pre.zw   <= n_pre.zw;
        r_pre.den  <= n_pre.den;
        r_pre.lane <= n_pre.lane;
        r_pre.res  <= n_pre.res;
        r_pre.flt  <= n_pre.flt;
    end

    // Divider chain: one quotient bit per cell.
    assign w_chain[0] = r_pre;
    for (genvar k = 0; k < NCELL; k++) begin : g_cell
        vt44_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_d     (w_chain[k]),
            .o_d     (w_chain[k+1])
        );
    end
    assign w_last = w_chain[NCELL];

    // Round the quotients and saturate.
    always_comb begin
        for (int j = 0; j < 3; j++) begin
            w_rnd[j] = {w_last.lane[j].rem, 1'b0} >= (vt44_pkg::REM_W+1)'(w_last.den);
            w_q[j]   = {1'b0, w_last.lane[j].quo} + (vt44_pkg::Q_W+1)'(w_rnd[j]);
            if (w_last.lane[j].neg) begin
                w_sat[j] = w_last.lane[j].ovf || (w_q[j] > (vt44_pkg::Q_W+1)'(33'h0_8000_0000));
                w_val[j] = w_sat[j] ? 32'h8000_0000 : -w_q[j][31:0];
            end else begin
                w_sat[j] = w_last.lane[j].ovf || (w_q[j] > (vt44_pkg::Q_W+1)'(33'h0_7FFF_FFFF));
                w_val[j] = w_sat[j] ? 32'h7FFF_FFFF : w_q[j][31:0];
            end
        end
    end

    // Output registers and strobe.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= w_last.vld;
        end
        if (w_last.div && w_last.zw) begin
            r_x     <= '0;
            r_y     <= '0;
            r_z     <= '0;
            r_fault <= 1'b1;
        end else if (w_last.div) begin
            r_x     <= w_val[0];
            r_y     <= w_val[1];
            r_z     <= w_val[2];
            r_fault <= |w_sat;
        end else begin
            r_x     <= w_last.res[0];
            r_y     <= w_last.res[1];
            r_z     <= w_last.res[2];
            r_fault <= w_last.flt;
        end
    end

    assign o_done  = r_done;
    assign o_out_x = r_x;
    assign o_out_y = r_y;
    assign o_out_z = r_z;
    assign o_fault = r_fault;

    // Every accepted vertex comes out after the fixed latency.
    `VT44_ASSERT_SAME(a_latency, i_clk, i_rst_n, $past(start, LAT) && $past(i_rst_n, LAT) && $past(i_rst_n, LAT-1), o_done)
    // A zero w in projection mode gives zero coordinates and a fault; the check covers x and z.
    `VT44_ASSERT_NEXT(a_zero_w, i_clk, i_rst_n, w_last.vld && w_last.div && w_last.zw, o_fault && (o_out_x == '0) && (o_out_z == '0))
    // A strobe only follows an item leaving the divider chain.
    `VT44_ASSERT_SAME(a_done_src, i_clk, i_rst_n, o_done, $past(w_last.vld))

endmodule
